/* src/lsra_pkg.sv */
// Shared constants, types and allocation order for the linear-scan register allocator.
package lsra_pkg;

    localparam int NUM_REGS        = 16;
    localparam int POS_WIDTH       = 16;
    localparam int MAX_SPILL_SLOTS = 1024;

    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int SLOT_CNT_W = $clog2(MAX_SPILL_SLOTS + 1);
    localparam int SLOT_BYTES_SH = 3;   // eight bytes per slot
    localparam int ORDER_LEN  = 14;

    // Fixed output field widths
    localparam int REG_FW   = 4;
    localparam int SLOT_FW  = 10;
    localparam int AREA_FW  = 14;

    localparam int IN_DATA_W  = ((2 * POS_WIDTH + 7) / 8) * 8;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = ((REG_FW + SLOT_FW + AREA_FW + 1 + 7) / 8) * 8;
    localparam int OUT_USER_W = 8;

    typedef logic [IDX_W-1:0]      t_reg_idx;
    typedef logic [POS_WIDTH-1:0]  t_pos;
    typedef logic [SLOT_CNT_W-1:0] t_slot_cnt;

    // Frame and stack pointers, never handed out
    localparam t_reg_idx RBP_IDX = t_reg_idx'(6);
    localparam t_reg_idx RSP_IDX = t_reg_idx'(7);

    // rax, rcx, rdx, rsi, rdi, r8-r11, rbx, r12-r15
    localparam t_reg_idx ALLOC_ORDER [ORDER_LEN] = '{
        t_reg_idx'(0),  t_reg_idx'(1),  t_reg_idx'(2),  t_reg_idx'(4),
        t_reg_idx'(5),  t_reg_idx'(8),  t_reg_idx'(9),  t_reg_idx'(10),
        t_reg_idx'(11), t_reg_idx'(3),  t_reg_idx'(12), t_reg_idx'(13),
        t_reg_idx'(14), t_reg_idx'(15)
    };

endpackage

/* src/linear_scan_reg_alloc.sv */
// Linear-scan register allocator: one live interval in, one register or spill slot out.
//
//  Channel  Dir  Fields (lowest bit first)
//  -------  ---  ---------------------------------------------------------------
//  s_axis   in   tdata: iv_start, end_pos           tuser: iv_class, new_function
//  m_axis   out  tdata: granted_reg, slot_idx,      tuser: spilled
//                       spill_area_bytes, spill_overflow
//
//  An item goes from acceptance to result through an accept step, a sweep of the
//  interval-end memory through its single read port (expiry check on each busy
//  register), a drain of the read pipeline and the allocate step.
//  A result waits in the output register; the next item is accepted meanwhile,
//  and only the allocate step holds if that register is still occupied.
//  i_rst_n (synchronous, active low) clears the busy bits, the slot counter and
//  all control state; the end-position memory needs no clearing pass.
module linear_scan_reg_alloc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lsra_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // iv_start, end_pos
    input  logic [lsra_pkg::IN_USER_W-1:0]  s_axis_tuser,  // iv_class, new_function
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lsra_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // granted_reg, slot_idx,
                                                           // spill_area_bytes, spill_overflow
    output logic [lsra_pkg::OUT_USER_W-1:0] m_axis_tuser   // spilled
);
    import lsra_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_ALLOC = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [NUM_REGS-1:0] r_busy;
    t_slot_cnt           r_slots;
    t_reg_idx            r_idx;

    // Current item
    t_pos r_start;
    t_pos r_end;
    logic r_is_gp;

    // Interval-end memory, one read and one write port
    t_pos     mem_end [NUM_REGS];
    t_pos     r_rd_data;
    logic     r_chk_vld;
    t_reg_idx r_chk_idx;

    // Output register
    logic                  r_out_vld;
    logic [REG_FW-1:0]     r_out_reg;
    logic                  r_out_spilled;
    logic [SLOT_FW-1:0]    r_out_slot;
    logic [AREA_FW-1:0]    r_out_area;
    logic                  r_out_ovf;

    logic      in_fire;
    logic      alloc_go;
    logic      found;
    t_reg_idx  found_idx;
    logic      grant;
    logic      full;
    t_slot_cnt n_slots;
    logic      expire;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign alloc_go      = (r_state == ST_ALLOC) && (!r_out_vld || m_axis_tready);

    // Expiry check on the entry read in the previous cycle
    assign expire = r_chk_vld && r_busy[r_chk_idx] && (r_rd_data <= r_start);

    // First free register in the fixed order
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int k = ORDER_LEN - 1; k >= 0; k--) begin
            if (!r_busy[ALLOC_ORDER[k]]) begin
                found     = 1'b1;
                found_idx = ALLOC_ORDER[k];
            end
        end
    end

    assign grant   = r_is_gp && found;
    assign full    = (r_slots >= t_slot_cnt'(MAX_SPILL_SLOTS));
    assign n_slots = (!grant && !full) ? r_slots + t_slot_cnt'(1) : r_slots;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (r_idx == t_reg_idx'(NUM_REGS - 1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_ALLOC;
            ST_ALLOC: begin
                if (alloc_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_busy    <= '0;
            r_slots   <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == ST_SWEEP);
            if (in_fire) begin
                r_idx <= '0;
                // New function: drop all bindings and the spill area
                if (s_axis_tuser[1]) begin
                    r_busy  <= '0;
                    r_slots <= '0;
                end
            end else if (r_state == ST_SWEEP) begin
                r_idx <= r_idx + t_reg_idx'(1);
            end
            if (expire) r_busy[r_chk_idx] <= 1'b0;
            if (alloc_go) begin
                if (grant) r_busy[found_idx] <= 1'b1;
                r_slots   <= n_slots;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Item and pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_start <= s_axis_tdata[POS_WIDTH-1:0];
            r_end   <= s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
            r_is_gp <= !s_axis_tuser[0];
        end
        r_chk_idx <= r_idx;
    end

    // Memory: read the swept entry, write the end of a newly granted register
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem_end[r_idx];
        if (alloc_go && grant) mem_end[found_idx] <= r_end;
    end

    // Result
    always_ff @(posedge i_clk) begin
        if (alloc_go) begin
            r_out_reg     <= grant ? REG_FW'(found_idx) : '0;
            r_out_spilled <= !grant;
            r_out_ovf     <= !grant && full;
            if (grant) begin
                r_out_slot <= '0;
            end else if (full) begin
                r_out_slot <= SLOT_FW'(MAX_SPILL_SLOTS - 1);
            end else begin
                r_out_slot <= SLOT_FW'(r_slots);
            end
            r_out_area <= AREA_FW'({n_slots, {SLOT_BYTES_SH{1'b0}}});
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_ovf, r_out_area, r_out_slot, r_out_reg});
    assign m_axis_tuser  = OUT_USER_W'(r_out_spilled);

`ifndef SYNTHESIS
    // Frame and stack pointers never become busy
    a_no_fp_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy[RBP_IDX] && !r_busy[RSP_IDX])
        else $error("rbp or rsp marked busy");

    // Slot counter saturates at its limit
    a_slot_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots <= t_slot_cnt'(MAX_SPILL_SLOTS))
        else $error("spill slot counter beyond limit");

    // A result is loaded only by the allocate step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_ALLOC))
        else $error("result appeared outside allocate step");

    // An accepted item starts its sweep at entry zero
    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_SWEEP) && (r_idx == '0))
        else $error("sweep did not start after accept");
`endif

endmodule

/* sim/linear_scan_reg_alloc_tb.sv */
// Self-checking testbench for the linear-scan register allocator, with random stalls on both streams.
module linear_scan_reg_alloc_tb;

    import lsra_pkg::*;

    localparam int CLK_HALF   = 2;
    localparam int RESET_CYC  = 2;
    localparam int IDLE_PCT   = 17;
    localparam int STALL_MAX  = 4000;   // cycles with no handshake before giving up
    localparam int DRAIN_CYC  = 40;     // idle time kept after the last result before the summary
    localparam int N_ITEMS    = 1950;
    localparam int SLOT_LIMIT = 1024;
    localparam int POS_MAX    = 65535;
    localparam bit CLS_GP     = 1'b0;
    localparam bit CLS_FP     = 1'b1;

    // Grant order: rax, rcx, rdx, rsi, rdi, r8-r11, rbx, r12-r15 (rbp and rsp left out)
    localparam bit [3:0] GRANT_ORDER [14] = '{
        4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd8, 4'd9, 4'd10,
        4'd11, 4'd3, 4'd12, 4'd13, 4'd14, 4'd15
    };

    typedef struct {
        bit [15:0] iv_start;
        bit [15:0] end_pos;
        bit        iv_class;
        bit        new_function;
    } t_interval;

    typedef struct {
        bit [3:0]  granted_reg;
        bit        spilled;
        bit [9:0]  slot_idx;
        bit [13:0] spill_area_bytes;
        bit        spill_overflow;
    } t_alloc;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // iv_start, end_pos
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // iv_class, new_function
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // granted_reg, slot_idx,
                                                // spill_area_bytes, spill_overflow
    logic [OUT_USER_W-1:0] m_axis_tuser;        // spilled

    linear_scan_reg_alloc DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    t_interval pending_intervals [$];
    t_alloc    expected_allocs [$];
    t_interval on_bus;

    // Allocator mirror: busy flags, end positions and the spill slot count
    bit        busy_mirror [16];
    bit [15:0] end_mirror [16];
    int        slots_mirror;

    int n_sent, n_recv, n_errors, stall_cnt;
    int n_granted, n_spilled, n_overflow, n_fresh;

    // Switch idling off for a stretch in the middle of the run
    function automatic bit take_idle(input int count);
        if (count >= 700 && count < 1000)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Work out the allocation for one accepted interval and queue it
    task automatic predict_alloc(input t_interval iv);
        t_alloc r;
        bit     got;
        r   = '{default: '0};
        got = 1'b0;
        if (iv.new_function) begin
            for (int i = 0; i < 16; i++) begin
                busy_mirror[i] = 1'b0;
                end_mirror[i]  = '0;
            end
            slots_mirror = 0;
            n_fresh++;
        end
        // expire anything that ended at or before this start, whatever its class
        for (int i = 0; i < 16; i++)
            if (busy_mirror[i] && end_mirror[i] <= iv.iv_start)
                busy_mirror[i] = 1'b0;
        if (iv.iv_class == CLS_GP) begin
            for (int k = 0; k < 14; k++) begin
                if (!got && !busy_mirror[GRANT_ORDER[k]]) begin
                    busy_mirror[GRANT_ORDER[k]] = 1'b1;
                    end_mirror[GRANT_ORDER[k]]  = iv.end_pos;
                    r.granted_reg = GRANT_ORDER[k];
                    got = 1'b1;
                end
            end
        end
        if (got) begin
            n_granted++;
        end else begin
            r.spilled = 1'b1;
            n_spilled++;
            if (slots_mirror < SLOT_LIMIT) begin
                r.slot_idx = 10'(slots_mirror);
                slots_mirror++;
            end else begin
                // counter saturated: hold it and flag the overflow
                r.slot_idx       = 10'(SLOT_LIMIT - 1);
                r.spill_overflow = 1'b1;
                n_overflow++;
            end
        end
        r.spill_area_bytes = 14'(slots_mirror * 8);
        expected_allocs.push_back(r);
    endtask

    task automatic add_interval(input int s, input int e, input bit cls, input bit fresh);
        t_interval iv;
        iv.iv_start     = 16'(s);
        iv.end_pos      = 16'(e);
        iv.iv_class     = cls;
        iv.new_function = fresh;
        pending_intervals.push_back(iv);
    endtask

    function automatic int clamp_pos(input int p);
        return (p > POS_MAX) ? POS_MAX : p;
    endfunction

    // Driver: present the next interval once the previous one has been taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_alloc(on_bus);
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_intervals.size() > 0 && !take_idle(n_sent)) begin
                    on_bus = pending_intervals.pop_front();
                    s_axis_tdata  <= {on_bus.end_pos, on_bus.iv_start};
                    s_axis_tuser  <= {6'b0, on_bus.new_function, on_bus.iv_class};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side at random and check each accepted result
    always @(posedge i_clk) begin
        t_alloc exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !take_idle(n_recv);
            if (m_axis_tvalid && m_axis_tready) begin
                n_recv++;
                if (expected_allocs.size() == 0) begin
                    $error("result with nothing expected: tdata=%h tuser=%h",
                           m_axis_tdata, m_axis_tuser);
                    n_errors++;
                end else begin
                    exp_r = expected_allocs.pop_front();
                    if (m_axis_tdata[3:0] !== exp_r.granted_reg) begin
                        $error("granted_reg: expected %0d, got %0d",
                               exp_r.granted_reg, m_axis_tdata[3:0]);
                        n_errors++;
                    end
                    if (m_axis_tuser[0] !== exp_r.spilled) begin
                        $error("spilled: expected %0d, got %0d",
                               exp_r.spilled, m_axis_tuser[0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[13:4] !== exp_r.slot_idx) begin
                        $error("slot_idx: expected %0d, got %0d",
                               exp_r.slot_idx, m_axis_tdata[13:4]);
                        n_errors++;
                    end
                    if (m_axis_tdata[27:14] !== exp_r.spill_area_bytes) begin
                        $error("spill_area_bytes: expected %0d, got %0d",
                               exp_r.spill_area_bytes, m_axis_tdata[27:14]);
                        n_errors++;
                    end
                    if (m_axis_tdata[28] !== exp_r.spill_overflow) begin
                        $error("spill_overflow: expected %0d, got %0d",
                               exp_r.spill_overflow, m_axis_tdata[28]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STALL_MAX, expected_allocs.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int pos, len, e, roll;
        bit cls;

        // Directed: fill every grantable register, then spill
        add_interval(0, 0, CLS_GP, 1'b1);                 // rax, ends at once
        for (int i = 0; i < 14; i++)
            add_interval(0, POS_MAX, CLS_GP, 1'b0);       // rax freed at start 0, then the rest
        add_interval(1, POS_MAX, CLS_GP, 1'b0);           // all busy: spill to slot 0
        add_interval(2, 10, CLS_FP, 1'b0);                // float always spills
        add_interval(POS_MAX, POS_MAX, CLS_GP, 1'b0);     // top start frees everything
        add_interval(5, 3, CLS_GP, 1'b0);                 // unsorted and ends before it starts
        add_interval(4, 4, CLS_FP, 1'b0);
        add_interval(POS_MAX, 0, CLS_FP, 1'b1);           // new function resets the slot count
        add_interval(21845, 43690, CLS_GP, 1'b1);         // alternating bit patterns
        add_interval(43690, 21845, CLS_GP, 1'b0);

        // Spill storm: long-lived, mostly float intervals past the slot limit
        pos = $urandom_range(0, 1000);
        for (int i = 0; i < 1100; i++) begin
            pos = clamp_pos(pos + $urandom_range(0, 3));
            cls = ($urandom_range(99) < 85) ? CLS_FP : CLS_GP;
            add_interval(pos, clamp_pos(pos + $urandom_range(0, 20000)), cls, i == 0);
        end

        // Ordinary functions, sorted by start, with some noise mixed in
        while (pending_intervals.size() < N_ITEMS) begin
            len = $urandom_range(1, 60);
            pos = ($urandom_range(99) < 10) ? $urandom_range(60000, POS_MAX)
                                            : $urandom_range(0, 2000);
            for (int i = 0; i < len; i++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    add_interval($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                                 1'($urandom_range(1)), i == 0 || $urandom_range(99) < 25);
                end else begin
                    pos = clamp_pos(pos + $urandom_range(0, 40));
                    e   = ($urandom_range(99) < 10) ? POS_MAX
                                                    : clamp_pos(pos + $urandom_range(0, 400));
                    cls = ($urandom_range(99) < 15) ? CLS_FP : CLS_GP;
                    add_interval(pos, e, cls, i == 0);
                end
            end
        end

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every interval is in, then drain the results
        while (pending_intervals.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_allocs.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d intervals in %0d functions: %0d registers granted, %0d spills",
                 n_sent, n_fresh, n_granted, n_spilled);
        $display("%0d spills past a full slot counter, %0d results checked, %0d mismatches",
                 n_overflow, n_recv, n_errors);
        if (n_errors == 0 && expected_allocs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
